/* hw/rtl/xmae_pkg.sv */
// shared types, constants and the instruction encoding function
// for the mov/alu encoder; depends on nothing
package xmae_pkg;

   localparam logic [1:0] KIND_REG = 2'd0;
   localparam logic [1:0] KIND_MEM = 2'd1;
   localparam logic [1:0] KIND_IMM = 2'd2;

   localparam logic [1:0] OP_MOV = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_SUB = 2'd2;
   localparam logic [1:0] OP_CMP = 2'd3;

   localparam logic [1:0] DISP_NONE = 2'd0;
   localparam logic [1:0] DISP_BYTE = 2'd1;
   localparam logic [1:0] DISP_WORD = 2'd2;

   localparam logic [7:0] MOV_RM_OPC  = 8'h88;
   localparam logic [7:0] MOV_RI_OPC  = 8'hB0;
   localparam logic [7:0] MOV_ST_OPC  = 8'hA2;
   localparam logic [7:0] MOV_LD_OPC  = 8'hA0;
   localparam logic [7:0] MOV_MI_OPC  = 8'hC6;
   localparam logic [7:0] ALU_IMM_OPC = 8'h80;
   localparam logic [7:0] MODRM_REG   = 8'hC0;
   localparam logic [7:0] ADD_RM_OPC  = 8'h00;
   localparam logic [7:0] SUB_RM_OPC  = 8'h28;
   localparam logic [7:0] CMP_RM_OPC  = 8'h38;
   localparam logic [7:0] ADD_ACC_OPC = 8'h04;
   localparam logic [7:0] SUB_ACC_OPC = 8'h2C;
   localparam logic [7:0] CMP_ACC_OPC = 8'h3C;

   localparam logic [2:0] EXT_ADD = 3'd0;
   localparam logic [2:0] EXT_SUB = 3'd5;
   localparam logic [2:0] EXT_CMP = 3'd7;

   localparam int MAX_BYTES = 6;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  dst_kind;
      logic [1:0]  src_kind;
      logic        word_op;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic [2:0]  mem_rm;
      logic        has_base;
      logic        has_index;
      logic [1:0]  disp_kind;
      logic [15:0] disp_data;
      logic [15:0] imm_value;
   } req_payload_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] code;
      logic [2:0]                last_idx;
      logic                      unsup;
   } enc_type;

   function automatic logic [7:0] alu_rm_opc(input logic [1:0] op);
      logic [7:0] r;
      case (op)
         OP_SUB:  r = SUB_RM_OPC;
         OP_CMP:  r = CMP_RM_OPC;
         default: r = ADD_RM_OPC;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] alu_acc_opc(input logic [1:0] op);
      logic [7:0] r;
      case (op)
         OP_ADD:  r = ADD_ACC_OPC;
         OP_SUB:  r = SUB_ACC_OPC;
         OP_CMP:  r = CMP_ACC_OPC;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] alu_ext(input logic [1:0] op);
      logic [2:0] r;
      case (op)
         OP_SUB:  r = EXT_SUB;
         OP_CMP:  r = EXT_CMP;
         default: r = EXT_ADD;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] mod_bits(input logic direct, input logic [1:0] dk);
      logic [1:0] r;
      if (direct) begin
         r = 2'd0;
      end else begin
         case (dk)
            DISP_BYTE: r = 2'd1;
            DISP_WORD: r = 2'd2;
            default:   r = 2'd0;
         endcase
      end
      return r;
   endfunction

   function automatic enc_type encode_instr(input req_payload_type q);
      enc_type                   e;
      logic [MAX_BYTES-1:0][7:0] b;
      logic [2:0]                n;
      logic                      mov;
      logic                      w;
      logic                      fit;
      logic                      s;
      logic                      reg_dst;
      logic                      direct;
      logic [2:0]                rg;
      logic [7:0]                ilo;
      logic [7:0]                ihi;
      logic [7:0]                dlo;
      logic [7:0]                dhi;
      b       = '0;
      n       = 3'd0;
      mov     = (q.req_type == OP_MOV);
      w       = q.word_op;
      fit     = (q.imm_value[15:7] == 9'h000) || (q.imm_value[15:7] == 9'h1FF);
      s       = w & fit;
      ilo     = q.imm_value[7:0];
      ihi     = q.imm_value[15:8];
      dlo     = q.disp_data[7:0];
      dhi     = q.disp_data[15:8];
      reg_dst = (q.dst_kind == KIND_REG);
      rg      = reg_dst ? q.dst_reg : q.src_reg;
      direct  = 1'b0;

      if (q.dst_kind == KIND_REG && q.src_kind == KIND_REG) begin
         b[0] = (mov ? MOV_RM_OPC : alu_rm_opc(q.req_type)) | {7'd0, w};
         b[1] = {2'b11, q.src_reg, q.dst_reg};
         n    = 3'd2;
      end else if (q.dst_kind == KIND_REG && q.src_kind == KIND_IMM) begin
         if (mov) begin
            b[0] = MOV_RI_OPC | {4'd0, w, q.dst_reg};
            b[1] = ilo;
            b[2] = ihi;
            n    = w ? 3'd3 : 3'd2;
         end else if (q.dst_reg == 3'd0) begin
            b[0] = alu_acc_opc(q.req_type) | {7'd0, w};
            b[1] = ilo;
            b[2] = ihi;
            n    = w ? 3'd3 : 3'd2;
         end else begin
            b[0] = ALU_IMM_OPC | {6'd0, s, w};
            b[1] = MODRM_REG | {2'b00, alu_ext(q.req_type), q.dst_reg};
            b[2] = ilo;
            b[3] = ihi;
            n    = (w && !fit) ? 3'd4 : 3'd3;
         end
      end else if ((q.dst_kind == KIND_REG && q.src_kind == KIND_MEM) ||
                   (q.dst_kind == KIND_MEM && q.src_kind == KIND_REG)) begin
         direct = !q.has_base;
         if (mov && rg == 3'd0 && direct) begin
            b[0] = (reg_dst ? MOV_LD_OPC : MOV_ST_OPC) | {7'd0, w};
            b[1] = dlo;
            b[2] = dhi;
            n    = 3'd3;
         end else begin
            b[0] = (mov ? MOV_RM_OPC : alu_rm_opc(q.req_type)) | {6'd0, reg_dst, w};
            b[1] = {mod_bits(direct, q.disp_kind), rg, q.mem_rm};
            n    = 3'd2;
            if (q.disp_kind == DISP_BYTE) begin
               b[2] = dlo;
               n    = 3'd3;
            end else if (q.disp_kind == DISP_WORD) begin
               b[2] = dlo;
               b[3] = dhi;
               n    = 3'd4;
            end
         end
      end else if (q.dst_kind == KIND_MEM && q.src_kind == KIND_IMM) begin
         if (mov) begin
            direct = !q.has_base && !q.has_index;
            b[0]   = MOV_MI_OPC | {7'd0, w};
            b[1]   = {mod_bits(direct, q.disp_kind), 3'd0, q.mem_rm};
         end else begin
            direct = !q.has_base;
            b[0]   = ALU_IMM_OPC | {6'd0, s, w};
            b[1]   = {mod_bits(direct, q.disp_kind), alu_ext(q.req_type), q.mem_rm};
         end
         n = 3'd2;
         if (q.disp_kind == DISP_BYTE) begin
            b[2] = dlo;
            n    = 3'd3;
         end else if (q.disp_kind == DISP_WORD) begin
            b[2] = dlo;
            b[3] = dhi;
            n    = 3'd4;
         end
         b[n] = ilo;
         n    = n + 3'd1;
         if (mov ? w : (w && !fit)) begin
            b[n] = ihi;
            n    = n + 3'd1;
         end
      end

      if (n == 3'd0) begin
         e.code     = '0;
         e.last_idx = 3'd0;
         e.unsup    = 1'b1;
      end else begin
         e.code     = b;
         e.last_idx = n - 3'd1;
         e.unsup    = 1'b0;
      end
      return e;
   endfunction

endpackage

/* hw/rtl/xmae_req_if.sv */
// request channel of the mov/alu encoder: valid, ready and instruction fields
// depends on nothing
interface xmae_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [1:0]  dst_kind;
   logic [1:0]  src_kind;
   logic        word_op;
   logic [2:0]  dst_reg;
   logic [2:0]  src_reg;
   logic [2:0]  mem_rm;
   logic        has_base;
   logic        has_index;
   logic [1:0]  disp_kind;
   logic signed [15:0] disp_data;
   logic signed [15:0] imm_value;

   modport source (
      output valid, req_type, dst_kind, src_kind, word_op, dst_reg, src_reg, mem_rm,
             has_base, has_index, disp_kind, disp_data, imm_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, dst_kind, src_kind, word_op, dst_reg, src_reg, mem_rm,
             has_base, has_index, disp_kind, disp_data, imm_value,
      output ready
   );
endinterface

/* hw/rtl/xmae_rsp_if.sv */
// response channel of the mov/alu encoder: one code byte per transfer
// depends on nothing
interface xmae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic [2:0] byte_index;
   logic       last_byte;
   logic       unsupported;

   modport source (
      output valid, code_byte, byte_index, last_byte, unsupported,
      input  ready
   );
   modport sink (
      input  valid, code_byte, byte_index, last_byte, unsupported,
      output ready
   );
endinterface

/* hw/rtl/xmae_front.sv */
// front end: takes a request and encodes it into a full byte block
// depends on xmae_pkg and xmae_req_if
module xmae_front (
   xmae_req_if.sink          req_chan,
   input  logic              q_full,
   output logic              q_push,
   output xmae_pkg::enc_type q_wdata
);
   xmae_pkg::req_payload_type pay;

   always_comb begin
      pay.req_type   = req_chan.req_type;
      pay.dst_kind   = req_chan.dst_kind;
      pay.src_kind   = req_chan.src_kind;
      pay.word_op    = req_chan.word_op;
      pay.dst_reg    = req_chan.dst_reg;
      pay.src_reg    = req_chan.src_reg;
      pay.mem_rm     = req_chan.mem_rm;
      pay.has_base   = req_chan.has_base;
      pay.has_index  = req_chan.has_index;
      pay.disp_kind  = req_chan.disp_kind;
      pay.disp_data  = req_chan.disp_data;
      pay.imm_value  = req_chan.imm_value;
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign q_wdata        = xmae_pkg::encode_instr(pay);
endmodule

/* hw/rtl/xmae_queue.sv */
// two-entry queue of encoded byte blocks between front and back end
// depends on xmae_pkg
module xmae_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xmae_pkg::enc_type wdata,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output xmae_pkg::enc_type rdata
);
   xmae_pkg::enc_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rdata    = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

/* hw/rtl/xmae_back.sv */
// back end: walks the head block one byte per cycle while the receiver is ready into the response register
// depends on xmae_pkg and xmae_rsp_if
module xmae_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  xmae_pkg::enc_type q_rdata,
   output logic              q_pop,
   xmae_rsp_if.source        rsp_chan
);
   logic       valid_ff;
   logic       valid_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic [7:0] code_ff;
   logic [7:0] code_in;
   logic [2:0] index_ff;
   logic       last_ff;
   logic       last_in;
   logic       unsup_ff;
   logic       load;

   assign load    = q_valid && (!valid_ff || rsp_chan.ready);
   assign last_in = (idx_ff == q_rdata.last_idx);
   assign q_pop   = load && last_in;
   assign code_in = q_rdata.code[idx_ff];

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_in ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= code_in;
         index_ff <= idx_ff;
         last_ff  <= last_in;
         unsup_ff <= q_rdata.unsup;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.code_byte   = code_ff;
   assign rsp_chan.byte_index  = index_ff;
   assign rsp_chan.last_byte   = last_ff;
   assign rsp_chan.unsupported = unsup_ff;
endmodule

/* hw/rtl/x86_16bit_mov_alu_encoder.sv */
// Encoder for 16-bit MOV, ADD, SUB and CMP instructions. Each request is encoded
// in the cycle it is accepted and parked in a two-entry queue; the back end then
// sends its machine code one byte per cycle while the receiver is ready, 2 to 6 bytes, the last one marked.
// An operand pair with no encoding gives a single byte of 0 flagged unsupported.
// The output byte register sets the rate: an instruction of n bytes takes n transfers
// on the response channel; the queue accepts new requests while earlier ones are
// still being sent, and each byte passes through the queue and the output register.
// Depends on xmae_pkg, xmae_req_if, xmae_rsp_if, xmae_front, xmae_queue, xmae_back.
module x86_16bit_mov_alu_encoder (
   input  logic       clock,
   input  logic       reset,
   xmae_req_if.sink   req_chan,
   xmae_rsp_if.source rsp_chan
);
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   xmae_pkg::enc_type q_wdata;
   xmae_pkg::enc_type q_rdata;

   xmae_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   xmae_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wdata    (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rdata    (q_rdata)
   );

   xmae_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_rdata  (q_rdata),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule

/* dv/tb_x86_16bit_mov_alu_encoder.sv */
// testbench for x86_16bit_mov_alu_encoder: directed and random instructions,
// each checked byte by byte against an in-bench encoding of the same request
// depends on xmae_pkg, xmae_req_if, xmae_rsp_if and the encoder rtl
module tb_x86_16bit_mov_alu_encoder;

   typedef struct packed {
      logic [7:0] code_byte;
      logic [2:0] byte_index;
      logic       last_byte;
      logic       unsupported;
   } rsp_item_type;

   logic clock;
   logic reset;

   xmae_req_if req_bus ();
   xmae_rsp_if rsp_bus ();

   x86_16bit_mov_alu_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   rsp_item_type expected_bytes[$];
   int           failures;
   int           items_sent;
   int           bytes_checked;
   int           unsup_seen;
   int           hold_cycles;
   bit           sender_idles;
   bit           receiver_idles;
   rsp_item_type got_byte;
   rsp_item_type want_byte;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic xmae_pkg::req_payload_type make_instr(
      input logic [1:0] op, input logic [1:0] k1, input logic [1:0] k2, input logic w,
      input logic [2:0] r1, input logic [2:0] r2, input logic [2:0] rm,
      input logic base, input logic idx, input logic [1:0] dk,
      input logic [15:0] disp, input logic [15:0] imm);
      xmae_pkg::req_payload_type q;
      q.req_type   = op;
      q.dst_kind   = k1;
      q.src_kind   = k2;
      q.word_op    = w;
      q.dst_reg    = r1;
      q.src_reg    = r2;
      q.mem_rm     = rm;
      q.has_base   = base;
      q.has_index  = idx;
      q.disp_kind  = dk;
      q.disp_data  = disp;
      q.imm_value  = imm;
      return q;
   endfunction

   // machine code of one instruction; returns the byte count, 0 when not encodable
   function automatic int build_code(input xmae_pkg::req_payload_type q,
                                     output logic [5:0][7:0] code);
      logic       mov;
      logic       w;
      logic       fit;
      logic       reg_dst;
      logic       direct;
      logic       mem_form;
      logic       imm_tail;
      logic       imm_hi;
      logic [2:0] rg;
      logic [2:0] ext;
      logic [1:0] mode;
      logic [7:0] rr_opc;
      logic [7:0] acc_opc;
      logic [2:0] n;
      code     = '0;
      n        = 3'd0;
      mov      = (q.req_type == xmae_pkg::OP_MOV);
      w        = q.word_op;
      fit      = (q.imm_value <= 16'h007F) || (q.imm_value >= 16'hFF80);
      reg_dst  = (q.dst_kind == xmae_pkg::KIND_REG);
      rg       = reg_dst ? q.dst_reg : q.src_reg;
      direct   = 1'b0;
      mem_form = 1'b0;
      imm_tail = 1'b0;
      imm_hi   = 1'b0;
      case (q.req_type)
         xmae_pkg::OP_ADD: begin
            rr_opc = xmae_pkg::ADD_RM_OPC; acc_opc = xmae_pkg::ADD_ACC_OPC;
            ext = xmae_pkg::EXT_ADD;
         end
         xmae_pkg::OP_SUB: begin
            rr_opc = xmae_pkg::SUB_RM_OPC; acc_opc = xmae_pkg::SUB_ACC_OPC;
            ext = xmae_pkg::EXT_SUB;
         end
         xmae_pkg::OP_CMP: begin
            rr_opc = xmae_pkg::CMP_RM_OPC; acc_opc = xmae_pkg::CMP_ACC_OPC;
            ext = xmae_pkg::EXT_CMP;
         end
         default: begin
            rr_opc = xmae_pkg::MOV_RM_OPC; acc_opc = 8'h00; ext = xmae_pkg::EXT_ADD;
         end
      endcase

      if (q.dst_kind == xmae_pkg::KIND_REG && q.src_kind == xmae_pkg::KIND_REG) begin
         code[0] = rr_opc | {7'd0, w};
         code[1] = xmae_pkg::MODRM_REG | {2'b00, q.src_reg, q.dst_reg};
         n = 3'd2;
      end else if (q.dst_kind == xmae_pkg::KIND_REG &&
                   q.src_kind == xmae_pkg::KIND_IMM) begin
         if (mov || q.dst_reg == 3'd0) begin
            code[0] = mov ? (xmae_pkg::MOV_RI_OPC | {4'd0, w, q.dst_reg})
                          : (acc_opc | {7'd0, w});
            code[1] = q.imm_value[7:0];
            code[2] = q.imm_value[15:8];
            n = w ? 3'd3 : 3'd2;
         end else begin
            code[0] = xmae_pkg::ALU_IMM_OPC | {6'd0, w & fit, w};
            code[1] = xmae_pkg::MODRM_REG | {2'b00, ext, q.dst_reg};
            code[2] = q.imm_value[7:0];
            code[3] = q.imm_value[15:8];
            n = (w && !fit) ? 3'd4 : 3'd3;
         end
      end else if ((q.dst_kind == xmae_pkg::KIND_REG &&
                    q.src_kind == xmae_pkg::KIND_MEM) ||
                   (q.dst_kind == xmae_pkg::KIND_MEM &&
                    q.src_kind == xmae_pkg::KIND_REG)) begin
         direct = !q.has_base;
         if (mov && rg == 3'd0 && direct) begin
            code[0] = (reg_dst ? xmae_pkg::MOV_LD_OPC : xmae_pkg::MOV_ST_OPC) |
                      {7'd0, w};
            code[1] = q.disp_data[7:0];
            code[2] = q.disp_data[15:8];
            n = 3'd3;
         end else begin
            code[0]  = rr_opc | {6'd0, reg_dst, w};
            mem_form = 1'b1;
         end
      end else if (q.dst_kind == xmae_pkg::KIND_MEM &&
                   q.src_kind == xmae_pkg::KIND_IMM) begin
         mem_form = 1'b1;
         imm_tail = 1'b1;
         rg       = ext;
         if (mov) begin
            direct  = !q.has_base && !q.has_index;
            code[0] = xmae_pkg::MOV_MI_OPC | {7'd0, w};
            imm_hi  = w;
         end else begin
            direct  = !q.has_base;
            code[0] = xmae_pkg::ALU_IMM_OPC | {6'd0, w & fit, w};
            imm_hi  = w && !fit;
         end
      end

      if (mem_form) begin
         if (direct) mode = 2'd0;
         else if (q.disp_kind == xmae_pkg::DISP_BYTE) mode = 2'd1;
         else if (q.disp_kind == xmae_pkg::DISP_WORD) mode = 2'd2;
         else mode = 2'd0;
         code[1] = {mode, rg, q.mem_rm};
         n = 3'd2;
         if (q.disp_kind == xmae_pkg::DISP_BYTE || q.disp_kind == xmae_pkg::DISP_WORD) begin
            code[n] = q.disp_data[7:0];
            n = n + 3'd1;
         end
         if (q.disp_kind == xmae_pkg::DISP_WORD) begin
            code[n] = q.disp_data[15:8];
            n = n + 3'd1;
         end
         if (imm_tail) begin
            code[n] = q.imm_value[7:0];
            n = n + 3'd1;
            if (imm_hi) begin
               code[n] = q.imm_value[15:8];
               n = n + 3'd1;
            end
         end
      end
      return int'(n);
   endfunction

   task automatic queue_expected(input xmae_pkg::req_payload_type q);
      logic [5:0][7:0] code;
      int              n;
      n = build_code(q, code);
      if (n == 0) begin
         expected_bytes.push_back('{8'h00, 3'd0, 1'b1, 1'b1});
      end else begin
         for (int i = 0; i < n; i++) begin
            expected_bytes.push_back('{code[i[2:0]], i[2:0], (i == n - 1), 1'b0});
         end
      end
   endtask

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
   endtask

   // rounds out fields with a bias towards accumulator and byte-fit cases
   function automatic xmae_pkg::req_payload_type random_instr(input bit well_formed);
      xmae_pkg::req_payload_type q;
      q.req_type   = 2'($urandom_range(3));
      q.word_op    = 1'($urandom_range(1));
      q.dst_reg    = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(7));
      q.src_reg    = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(7));
      q.mem_rm     = 3'($urandom_range(7));
      q.has_base   = 1'($urandom_range(1));
      q.has_index  = 1'($urandom_range(1));
      q.disp_kind  = 2'($urandom_range(3));
      q.disp_data  = 16'($urandom_range(16'hFFFF));
      case ($urandom_range(3))
         0: q.imm_value = 16'($urandom_range(255)) - 16'd128;
         1: begin
            case ($urandom_range(7))
               0: q.imm_value = 16'h007F;
               1: q.imm_value = 16'h0080;
               2: q.imm_value = 16'hFF80;
               3: q.imm_value = 16'hFF7F;
               4: q.imm_value = 16'h0000;
               5: q.imm_value = 16'hFFFF;
               6: q.imm_value = 16'h8000;
               default: q.imm_value = 16'h7FFF;
            endcase
         end
         default: q.imm_value = 16'($urandom_range(16'hFFFF));
      endcase
      if (well_formed) begin
         case ($urandom_range(4))
            0: begin
               q.dst_kind = xmae_pkg::KIND_REG; q.src_kind = xmae_pkg::KIND_REG;
            end
            1: begin
               q.dst_kind = xmae_pkg::KIND_REG; q.src_kind = xmae_pkg::KIND_IMM;
            end
            2: begin
               q.dst_kind = xmae_pkg::KIND_REG; q.src_kind = xmae_pkg::KIND_MEM;
            end
            3: begin
               q.dst_kind = xmae_pkg::KIND_MEM; q.src_kind = xmae_pkg::KIND_REG;
            end
            default: begin
               q.dst_kind = xmae_pkg::KIND_MEM; q.src_kind = xmae_pkg::KIND_IMM;
            end
         endcase
      end else begin
         q.dst_kind = 2'($urandom_range(3));
         q.src_kind = 2'($urandom_range(3));
      end
      return q;
   endfunction

   task automatic send_instr(input xmae_pkg::req_payload_type q);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.req_type   <= q.req_type;
      req_bus.dst_kind   <= q.dst_kind;
      req_bus.src_kind   <= q.src_kind;
      req_bus.word_op    <= q.word_op;
      req_bus.dst_reg    <= q.dst_reg;
      req_bus.src_reg    <= q.src_reg;
      req_bus.mem_rm     <= q.mem_rm;
      req_bus.has_base   <= q.has_base;
      req_bus.has_index  <= q.has_index;
      req_bus.disp_kind  <= q.disp_kind;
      req_bus.disp_data  <= q.disp_data;
      req_bus.imm_value  <= q.imm_value;
      req_bus.valid      <= 1'b1;
      queue_expected(q);
      items_sent++;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_instr(random_instr($urandom_range(99) < 85));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic test_reg_reg();
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_REG,
                            1'b1, 3'd7, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_REG, xmae_pkg::KIND_REG,
                            1'b0, 3'd0, 3'd7, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_SUB, xmae_pkg::KIND_REG, xmae_pkg::KIND_REG,
                            1'b1, 3'd3, 3'd5, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_CMP, xmae_pkg::KIND_REG, xmae_pkg::KIND_REG,
                            1'b0, 3'd6, 3'd2, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0000));
   endtask

   task automatic test_reg_imm();
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b0, 3'd5, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h007F));
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b1, 3'd7, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h8000));
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b1, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h1234));
      send_instr(make_instr(xmae_pkg::OP_SUB, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'hFFAB));
      send_instr(make_instr(xmae_pkg::OP_CMP, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b1, 3'd3, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'hFF80));
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b1, 3'd6, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0080));
      send_instr(make_instr(xmae_pkg::OP_SUB, xmae_pkg::KIND_REG, xmae_pkg::KIND_IMM,
                            1'b0, 3'd1, 3'd0, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'hFFFF));
   endtask

   task automatic test_reg_mem();
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_MEM,
                            1'b1, 3'd2, 3'd0, 3'd7, 1'b1, 1'b0, xmae_pkg::DISP_WORD,
                            16'h8001, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_MEM, xmae_pkg::KIND_REG,
                            1'b0, 3'd0, 3'd4, 3'd1, 1'b1, 1'b1, xmae_pkg::DISP_BYTE,
                            16'h00FF, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_CMP, xmae_pkg::KIND_REG, xmae_pkg::KIND_MEM,
                            1'b1, 3'd0, 3'd0, 3'd6, 1'b0, 1'b0, xmae_pkg::DISP_WORD,
                            16'h7FFF, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_SUB, xmae_pkg::KIND_MEM, xmae_pkg::KIND_REG,
                            1'b1, 3'd0, 3'd7, 3'd3, 1'b1, 1'b0, 2'd3,
                            16'h1234, 16'h0000));
   endtask

   task automatic test_acc_direct();
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_MEM,
                            1'b1, 3'd0, 3'd0, 3'd6, 1'b0, 1'b0, xmae_pkg::DISP_WORD,
                            16'hBEEF, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_MEM, xmae_pkg::KIND_REG,
                            1'b0, 3'd0, 3'd0, 3'd6, 1'b0, 1'b1, xmae_pkg::DISP_BYTE,
                            16'h0042, 16'h0000));
      // accumulator with a base register takes the general form
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_REG, xmae_pkg::KIND_MEM,
                            1'b0, 3'd0, 3'd0, 3'd2, 1'b1, 1'b0, xmae_pkg::DISP_BYTE,
                            16'hFF80, 16'h0000));
   endtask

   task automatic test_mem_imm();
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_MEM, xmae_pkg::KIND_IMM,
                            1'b1, 3'd0, 3'd0, 3'd6, 1'b0, 1'b0, xmae_pkg::DISP_WORD,
                            16'hFFFF, 16'hA55A));
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_MEM, xmae_pkg::KIND_IMM,
                            1'b0, 3'd0, 3'd0, 3'd4, 1'b0, 1'b1, xmae_pkg::DISP_BYTE,
                            16'h0080, 16'h00C3));
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_MEM, xmae_pkg::KIND_IMM,
                            1'b1, 3'd0, 3'd0, 3'd5, 1'b1, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'hFFF0));
      send_instr(make_instr(xmae_pkg::OP_CMP, xmae_pkg::KIND_MEM, xmae_pkg::KIND_IMM,
                            1'b1, 3'd0, 3'd0, 3'd0, 1'b1, 1'b1, xmae_pkg::DISP_WORD,
                            16'h8000, 16'h7FFF));
   endtask

   task automatic test_unsupported();
      send_instr(make_instr(xmae_pkg::OP_ADD, xmae_pkg::KIND_IMM, xmae_pkg::KIND_REG,
                            1'b1, 3'd1, 3'd2, 3'd0, 1'b0, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0001));
      send_instr(make_instr(xmae_pkg::OP_MOV, xmae_pkg::KIND_MEM, xmae_pkg::KIND_MEM,
                            1'b0, 3'd0, 3'd0, 3'd1, 1'b1, 1'b0, xmae_pkg::DISP_NONE,
                            16'h0000, 16'h0000));
      send_instr(make_instr(xmae_pkg::OP_CMP, 2'd3, 2'd3, 1'b1, 3'd7, 3'd7, 3'd7,
                            1'b1, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF));
   endtask

   task automatic test_random_mix();
      send_random(120);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_random(60);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_random(120);
   endtask

   // receiver holds off while the sender keeps offering, so the input backs up
   task automatic test_output_stall();
      sender_idles = 1'b0;
      hold_cycles  = 150;
      send_random(30);
      sender_idles = 1'b1;
   endtask

   task automatic test_drain_pause();
      send_random(10);
      wait_drained();
      send_random(10);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= !receiver_idles || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got_byte = '{rsp_bus.code_byte, rsp_bus.byte_index, rsp_bus.last_byte,
                      rsp_bus.unsupported};
         bytes_checked++;
         if (got_byte.unsupported === 1'b1) unsup_seen++;
         if (expected_bytes.size() == 0) begin
            log_failure($sformatf("unexpected byte %h idx %0d last %b unsup %b",
                                  got_byte.code_byte, got_byte.byte_index,
                                  got_byte.last_byte, got_byte.unsupported));
         end else begin
            want_byte = expected_bytes.pop_front();
            if (got_byte.code_byte !== want_byte.code_byte ||
                got_byte.byte_index !== want_byte.byte_index ||
                got_byte.last_byte !== want_byte.last_byte ||
                got_byte.unsupported !== want_byte.unsupported) begin
               log_failure($sformatf(
                  "byte exp %h/%0d/%b/%b got %h/%0d/%b/%b (code/idx/last/unsup)",
                  want_byte.code_byte, want_byte.byte_index, want_byte.last_byte,
                  want_byte.unsupported, got_byte.code_byte, got_byte.byte_index,
                  got_byte.last_byte, got_byte.unsupported));
            end
         end
      end
   end

   initial begin
      failures       = 0;
      items_sent     = 0;
      bytes_checked  = 0;
      unsup_seen     = 0;
      hold_cycles    = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      reset          = 1'b1;
      rsp_bus.ready  = 1'b0;
      req_bus.valid  = 1'b0;
      req_bus.req_type   = xmae_pkg::OP_MOV;
      req_bus.dst_kind   = xmae_pkg::KIND_REG;
      req_bus.src_kind   = xmae_pkg::KIND_REG;
      req_bus.word_op    = 1'b0;
      req_bus.dst_reg    = 3'd0;
      req_bus.src_reg    = 3'd0;
      req_bus.mem_rm     = 3'd0;
      req_bus.has_base   = 1'b0;
      req_bus.has_index  = 1'b0;
      req_bus.disp_kind  = xmae_pkg::DISP_NONE;
      req_bus.disp_data  = 16'd0;
      req_bus.imm_value  = 16'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reg_reg();
      test_reg_imm();
      test_reg_mem();
      test_acc_direct();
      test_mem_imm();
      test_unsupported();
      test_random_mix();
      test_output_stall();
      test_drain_pause();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (12) @(posedge clock);
      if (expected_bytes.size() != 0) log_failure("request bytes never arrived");

      $display("ran %0d instructions through all operand forms, %0d code bytes checked",
               items_sent, bytes_checked);
      $display("%0d unsupported results, idle gaps and a long output stall on the way",
               unsup_seen);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d failures", failures);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
